// ----- design/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar helpers for the Gregorian date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

    // Field widths
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned AMT_W    = 16;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned STATUS_W = 2;

    // Working year: holds the stored year plus a full 16-bit amount.
    localparam int unsigned WY_W = 17;

    // Largest year the 14-bit field can hold, and the default limit.
    localparam int unsigned YEAR_MAX       = 16383;
    localparam int unsigned YEAR_LIMIT_DEF = 9999;

    // Division by 25 and by 12 through a scaled reciprocal and a right shift.
    localparam int unsigned MUL_W      = 17;
    localparam int unsigned PROD_W     = 2 * MUL_W;
    localparam int unsigned PROD_SHIFT = 20;
    localparam int unsigned Q_W        = 13;
    localparam logic [MUL_W-1:0] RECIP_25 = 17'd41944;
    localparam logic [MUL_W-1:0] RECIP_12 = 17'd87382;
    localparam logic [MUL_W-1:0] DIV_25   = 17'd25;
    localparam logic [MUL_W-1:0] DIV_12   = 17'd12;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP    = 5'd29;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [ACT_W-1:0] {
        ACT_READ       = 3'd0,
        ACT_SET        = 3'd1,
        ACT_ADD_DAYS   = 3'd2,
        ACT_ADD_MONTHS = 3'd3,
        ACT_ADD_YEARS  = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MONTH = 2'd1,
        ST_BAD_DAY   = 2'd2,
        ST_YEAR_OVF  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULM,
        S_DIVM,
        S_MULY,
        S_LEAPY,
        S_DAY,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [AMT_W-1:0]   amount;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0]   out_year;
        logic [MONTH_W-1:0]  out_month;
        logic [DAY_W-1:0]    out_day;
        logic [STATUS_W-1:0] status;
    } t_out;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic capture;
        logic mul_year;
        logic mul_month;
        logic leap_upd;
        logic month_upd;
        logic day_step;
        logic set_ovf;
        logic check;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] in_act;
        logic [ACT_W-1:0] act;
        logic             left_zero;
        logic             fits;
        logic             wrap;
        logic             wrap_ovf;
    } t_dp_sts;

    // Month length; an invalid month gives zero so that no day fits.
    function automatic logic [DAY_W-1:0] days_in(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        if (month < MONTH_FIRST || month > MONTH_LAST) begin
            len = '0;
        end else if (month == MONTH_FEB && leap) begin
            len = FEB_LEAP;
        end else begin
            len = MONTH_LEN[month - MONTH_FIRST];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- design/gregorian_date_adder.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_adder
// Holds one Gregorian date and applies read, set, add-days, add-months and
// add-years commands, returning the date and a status for every command.
// ----------------------------------------------------------------------------
// One command is in flight at a time; its result beat is registered once the
// command has gone through its steps, and the next command may be accepted
// while that result still waits. Read goes straight to the result; set date
// and add years go through the year multiply, leap test and check; add months
// first splits the month total through the shared reciprocal multiplier before
// the leap test. Add days walks the calendar one month per cycle and on each new
// year goes back through the year multiply and leap test. YEAR_LIMIT is the
// largest storable year; values above 16383 act as 16383.
`default_nettype none

module gregorian_date_adder import gda_pkg::*; #(
    parameter int unsigned YEAR_LIMIT = YEAR_LIMIT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    gda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    gda_dp #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ----- design/gda_ctrl.sv -----
// ----------------------------------------------------------------------------
// gda_ctrl
// Command sequencer: decodes each accepted beat, steps the datapath through
// its multiply, leap, month-walk and check phases, and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_ctrl import gda_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_sts.in_act) inside
                        ACT_SET, ACT_ADD_DAYS, ACT_ADD_YEARS: n_state = S_MULY;
                        ACT_ADD_MONTHS:                        n_state = S_MULM;
                        default:                               n_state = S_DONE;
                    endcase
                end
            end
            S_MULM: begin
                o_cmd.mul_month = 1'b1;
                n_state         = S_DIVM;
            end
            S_DIVM: begin
                o_cmd.month_upd = 1'b1;
                n_state         = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul_year = 1'b1;
                n_state        = S_LEAPY;
            end
            S_LEAPY: begin
                o_cmd.leap_upd = 1'b1;
                n_state        = (i_sts.act == ACT_ADD_DAYS) ? S_DAY : S_CHECK;
            end
            S_DAY: begin
                if (i_sts.left_zero) begin
                    n_state = S_CHECK;
                end else if (i_sts.fits) begin
                    o_cmd.day_step = 1'b1;
                end else if (i_sts.wrap && i_sts.wrap_ovf) begin
                    o_cmd.set_ovf = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.wrap) begin
                    // New year: the leap flag has to be recomputed.
                    o_cmd.day_step = 1'b1;
                    n_state        = S_MULY;
                end else begin
                    o_cmd.day_step = 1'b1;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result register reloaded while a stalled beat is pending");

    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_in_stall)
        else $error("input not stalled after a command was captured");
`endif

endmodule

`default_nettype wire

// ----- design/gda_dp.sv -----
// ----------------------------------------------------------------------------
// gda_dp
// Date datapath: stored date, working date, shared reciprocal multiplier for
// the leap test and the month split, month-by-month day walk, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_dp import gda_pkg::*; #(
    parameter int unsigned YEAR_LIMIT = YEAR_LIMIT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in     i_in_data,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    output t_out         o_out_data
);

    localparam int unsigned YearCap = (YEAR_LIMIT > YEAR_MAX) ? YEAR_MAX : YEAR_LIMIT;
    localparam logic [WY_W-1:0] CapW = WY_W'(YearCap);

    logic [YEAR_W-1:0]  r_cur_year;
    logic [MONTH_W-1:0] r_cur_month;
    logic [DAY_W-1:0]   r_cur_day;

    logic [ACT_W-1:0]   r_act;
    logic [WY_W-1:0]    r_wy;
    logic [MONTH_W-1:0] r_wm;
    logic [DAY_W-1:0]   r_wd;
    logic [AMT_W-1:0]   r_left;
    logic [MUL_W-1:0]   r_mul_a;
    logic [PROD_W-1:0]  r_prod;
    logic               r_leap;
    t_status            r_status;
    t_out               r_out;

    logic [MUL_W-1:0]  mul_op;
    logic [MUL_W-1:0]  mul_k;
    logic [PROD_W-1:0] prod_n;
    logic [Q_W-1:0]    quot;
    logic [MUL_W-1:0]  rem25;
    logic [MUL_W-1:0]  rem12;
    logic              leap_n;
    logic [DAY_W-1:0]  dim;
    logic [MUL_W-1:0]  sum_dl;
    logic [AMT_W-1:0]  step_sub;
    logic              fits;
    logic              year_ovf;
    logic              month_bad;
    logic              day_bad;

    // Shared multiplier: the year for the divide-by-25 leap test, or the
    // month total for the divide-by-12 split.
    assign mul_op = i_cmd.mul_year ? MUL_W'(r_wy[YEAR_W-1:0]) : r_mul_a;
    assign mul_k  = i_cmd.mul_year ? RECIP_25 : RECIP_12;
    assign prod_n = mul_op * mul_k;

    assign quot  = r_prod[PROD_SHIFT+Q_W-1:PROD_SHIFT];
    assign rem25 = r_mul_a - MUL_W'(MUL_W'(quot) * DIV_25);
    assign rem12 = r_mul_a - MUL_W'(MUL_W'(quot) * DIV_12);

    // Divisible by 4, and either not by 100 or also by 400 (by 16 and by 25).
    assign leap_n = (r_mul_a[1:0] == 2'd0) && ((rem25 != '0) || (r_mul_a[3:0] == 4'd0));

    assign dim      = days_in(r_wm, r_leap);
    assign sum_dl   = MUL_W'(r_wd) + MUL_W'(r_left);
    assign fits     = sum_dl <= MUL_W'(dim);
    assign step_sub = AMT_W'(dim) - AMT_W'(r_wd) + AMT_W'(1);

    assign year_ovf  = r_wy > CapW;
    assign month_bad = (r_wm < MONTH_FIRST) || (r_wm > MONTH_LAST);
    assign day_bad   = (r_wd == '0) || (r_wd > dim);

    always_comb begin
        o_sts.in_act    = i_in_data.action;
        o_sts.act       = r_act;
        o_sts.left_zero = (r_left == '0);
        o_sts.fits      = fits;
        o_sts.wrap      = (r_wm == MONTH_LAST);
        o_sts.wrap_ovf  = (r_wy + WY_W'(1)) > CapW;
    end

    // Stored date; only a clean check writes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_year  <= YEAR_W'(2000);
            r_cur_month <= MONTH_FIRST;
            r_cur_day   <= DAY_W'(1);
        end else if (i_cmd.check && !year_ovf && !month_bad && !day_bad) begin
            r_cur_year  <= r_wy[YEAR_W-1:0];
            r_cur_month <= r_wm;
            r_cur_day   <= r_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act    <= i_in_data.action;
            r_status <= ST_OK;
            r_left   <= '0;
            unique case (i_in_data.action)
                ACT_SET: begin
                    r_wy <= WY_W'(i_in_data.in_year);
                    r_wm <= i_in_data.in_month;
                    r_wd <= i_in_data.in_day;
                end
                ACT_ADD_DAYS: begin
                    r_wy   <= WY_W'(r_cur_year);
                    r_wm   <= r_cur_month;
                    r_wd   <= r_cur_day;
                    r_left <= i_in_data.amount;
                end
                ACT_ADD_MONTHS: begin
                    r_wd    <= r_cur_day;
                    r_mul_a <= MUL_W'(r_cur_month) + MUL_W'(i_in_data.amount)
                               - MUL_W'(1);
                end
                ACT_ADD_YEARS: begin
                    r_wy <= WY_W'(r_cur_year) + WY_W'(i_in_data.amount);
                    r_wm <= r_cur_month;
                    r_wd <= r_cur_day;
                end
                default: begin
                    r_wy <= WY_W'(r_cur_year);
                    r_wm <= r_cur_month;
                    r_wd <= r_cur_day;
                end
            endcase
        end else if (i_cmd.mul_year) begin
            r_prod  <= prod_n;
            r_mul_a <= MUL_W'(r_wy[YEAR_W-1:0]);
        end else if (i_cmd.mul_month) begin
            r_prod <= prod_n;
        end else if (i_cmd.leap_upd) begin
            r_leap <= leap_n;
        end else if (i_cmd.month_upd) begin
            r_wy <= WY_W'(r_cur_year) + WY_W'(quot);
            r_wm <= rem12[MONTH_W-1:0] + MONTH_FIRST;
        end else if (i_cmd.day_step) begin
            if (fits) begin
                r_wd   <= sum_dl[DAY_W-1:0];
                r_left <= '0;
            end else begin
                r_left <= r_left - step_sub;
                r_wd   <= DAY_W'(1);
                if (r_wm == MONTH_LAST) begin
                    r_wm <= MONTH_FIRST;
                    r_wy <= r_wy + WY_W'(1);
                end else begin
                    r_wm <= r_wm + MONTH_W'(1);
                end
            end
        end else if (i_cmd.set_ovf) begin
            r_status <= ST_YEAR_OVF;
        end else if (i_cmd.check) begin
            if (year_ovf) begin
                r_status <= ST_YEAR_OVF;
            end else if (month_bad) begin
                r_status <= ST_BAD_MONTH;
            end else if (day_bad) begin
                r_status <= ST_BAD_DAY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_year  <= r_cur_year;
            r_out.out_month <= r_cur_month;
            r_out.out_day   <= r_cur_day;
            r_out.status    <= r_status;
        end
    end

    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_cur_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_month >= MONTH_FIRST) && (r_cur_month <= MONTH_LAST)
        && (r_cur_day != '0) && (r_cur_day <= days_in(r_cur_month, 1'b1)))
        else $error("stored date holds an impossible month or day");

    a_cur_year_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WY_W'(r_cur_year) <= CapW)
        else $error("stored year exceeds the year limit");

    a_left_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.day_step |=> (r_left < $past(r_left)))
        else $error("day walk did not consume any days");
`endif

endmodule

`default_nettype wire

// ----- bench/date_result_checker.sv -----
// ----------------------------------------------------------------------------
// date_result_checker
// Watches both channels of the Gregorian date adder, keeps its own copy of
// the stored date, and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
module date_result_checker import gda_pkg::*; #(
    parameter int unsigned YEAR_LIMIT = YEAR_LIMIT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_stall,
    input  wire t_in  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_stall,
    input  wire t_out i_out_data,
    output int        o_mismatches,
    output int        o_results_checked,
    output int        o_rejected
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned YEAR_CAP = (YEAR_LIMIT > YEAR_MAX) ? YEAR_MAX : YEAR_LIMIT;
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned FEBRUARY = 2;
    localparam int unsigned LEAP_FEB_LEN = 29;
    localparam int unsigned COMMON_LEN [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;

    t_out expected_dates [$];
    t_out want;
    int   mismatches = 0;
    int   checked = 0;
    int   rejected = 0;

    function automatic bit is_leap(int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    // An out-of-range month has length zero, so no day fits in it.
    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        if (m < 1 || m > MONTHS_PER_YEAR) return 0;
        if (m == FEBRUARY && is_leap(y)) return LEAP_FEB_LEN;
        return COMMON_LEN[m - 1];
    endfunction

    // Applies one command to the stored date and returns the result beat.
    function automatic t_out apply_command(t_in cmd);
        int unsigned y, m, d, left, dim, total, ny, nm;
        t_status     st;
        t_out        res;
        st = ST_OK;
        case (cmd.action)
            ACT_SET: begin
                if (cmd.in_year > YEAR_CAP) begin
                    st = ST_YEAR_OVF;
                end else if (cmd.in_month < 1 || cmd.in_month > MONTHS_PER_YEAR) begin
                    st = ST_BAD_MONTH;
                end else if (cmd.in_day < 1 ||
                             cmd.in_day > month_days(32'(cmd.in_year),
                                                     32'(cmd.in_month))) begin
                    st = ST_BAD_DAY;
                end else begin
                    cal_year  = cmd.in_year;
                    cal_month = cmd.in_month;
                    cal_day   = cmd.in_day;
                end
            end
            ACT_ADD_DAYS: begin
                y = 32'(cal_year);
                m = 32'(cal_month);
                d = 32'(cal_day);
                left = 32'(cmd.amount);
                while (left > 0 && st == ST_OK) begin
                    dim = month_days(y, m);
                    if (d + left <= dim) begin
                        d += left;
                        left = 0;
                    end else begin
                        left -= dim - d + 1;
                        d = 1;
                        m++;
                        if (m > MONTHS_PER_YEAR) begin
                            m = 1;
                            y++;
                            if (y > YEAR_CAP) st = ST_YEAR_OVF;
                        end
                    end
                end
                if (st == ST_OK) begin
                    cal_year  = YEAR_W'(y);
                    cal_month = MONTH_W'(m);
                    cal_day   = DAY_W'(d);
                end
            end
            ACT_ADD_MONTHS: begin
                total = 32'(cal_month) + 32'(cmd.amount) - 1;
                ny = 32'(cal_year) + total / MONTHS_PER_YEAR;
                nm = total % MONTHS_PER_YEAR + 1;
                if (ny > YEAR_CAP) begin
                    st = ST_YEAR_OVF;
                end else if (cal_day < 1 || cal_day > month_days(ny, nm)) begin
                    st = ST_BAD_DAY;
                end else begin
                    cal_year  = YEAR_W'(ny);
                    cal_month = MONTH_W'(nm);
                end
            end
            ACT_ADD_YEARS: begin
                ny = 32'(cal_year) + 32'(cmd.amount);
                if (ny > YEAR_CAP) begin
                    st = ST_YEAR_OVF;
                end else if (cal_day < 1 || cal_day > month_days(ny, 32'(cal_month))) begin
                    st = ST_BAD_DAY;
                end else begin
                    cal_year = YEAR_W'(ny);
                end
            end
            default: begin
                // Read and the spare action codes leave the date alone.
            end
        endcase
        res.out_year  = cal_year;
        res.out_month = cal_month;
        res.out_day   = cal_day;
        res.status    = st;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_year  = YEAR_W'(2000);
            cal_month = MONTH_W'(1);
            cal_day   = DAY_W'(1);
            expected_dates.delete();
        end else begin
            // A result can never belong to a command taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("result beat %p with no command pending",
                                              i_out_data));
                end else begin
                    want = expected_dates.pop_front();
                    checked++;
                    if (i_out_data.out_year !== want.out_year)
                        report_mismatch($sformatf("year %0d, expected %0d",
                                                  i_out_data.out_year, want.out_year));
                    if (i_out_data.out_month !== want.out_month)
                        report_mismatch($sformatf("month %0d, expected %0d",
                                                  i_out_data.out_month, want.out_month));
                    if (i_out_data.out_day !== want.out_day)
                        report_mismatch($sformatf("day %0d, expected %0d",
                                                  i_out_data.out_day, want.out_day));
                    if (i_out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_data.status, want.status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_dates.push_back(apply_command(i_in_data));
                if (expected_dates[$].status != ST_OK) rejected++;
            end
        end
        o_mismatches      <= mismatches;
        o_results_checked <= checked;
        o_rejected        <= rejected;
    end

endmodule

// ----- bench/gregorian_date_adder_tb.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_adder_tb
// Drives directed corner commands and a long random command stream into the
// date adder with random idle cycles on both sides and one long output hold;
// the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module gregorian_date_adder_tb import gda_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned YEAR_LIMIT   = YEAR_LIMIT_DEF;
    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_ITEMS = 1725;
    localparam int          CALM_ITEMS   = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          QUIET_LIMIT  = 20000;
    localparam int          IDLE_PCT     = 28;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in  i_in_data = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    int mismatches;
    int results_checked;
    int rejected;
    int sent = 0;
    int n_directed = 0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;

    gregorian_date_adder #(.YEAR_LIMIT(YEAR_LIMIT)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    date_result_checker #(.YEAR_LIMIT(YEAR_LIMIT)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_in_data         (i_in_data),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_out_data        (o_out_data),
        .o_mismatches      (mismatches),
        .o_results_checked (results_checked),
        .o_rejected        (rejected)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Output side: random stalls, plus one long hold on request so that the
    // block fills up and pushes back on its input.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic send_command(input t_in cmd);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_fields(input logic [ACT_W-1:0] act, input int unsigned y,
                               input int unsigned m, input int unsigned d,
                               input int unsigned amt);
        t_in cmd;
        cmd.action   = act;
        cmd.in_year  = YEAR_W'(y);
        cmd.in_month = MONTH_W'(m);
        cmd.in_day   = DAY_W'(d);
        cmd.amount   = AMT_W'(amt);
        send_command(cmd);
    endtask

    // Mostly modest amounts, now and then a wide one or the full 16-bit range.
    function automatic logic [AMT_W-1:0] pick_amount(int unsigned usual,
                                                     int unsigned wide);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return AMT_W'($urandom_range(0, usual));
        if (r < 92) return AMT_W'($urandom_range(0, wide));
        return AMT_W'($urandom);
    endfunction

    function automatic t_in random_command();
        t_in         cmd;
        logic [63:0] noise;
        int unsigned pick;
        // Fields a command does not use keep their random content.
        noise = {$urandom, $urandom};
        cmd = noise[$bits(t_in)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            cmd.action = ACT_READ;
        end else if (pick < 30) begin
            cmd.action = ACT_SET;
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 9) == 0)
                    cmd.in_year = YEAR_W'($urandom_range(YEAR_LIMIT - 100, YEAR_LIMIT));
                else
                    cmd.in_year = YEAR_W'($urandom_range(0, YEAR_LIMIT));
                cmd.in_month = MONTH_W'($urandom_range(MONTH_FIRST, MONTH_LAST));
                cmd.in_day   = DAY_W'($urandom_range(1, 31));
            end
        end else if (pick < 55) begin
            cmd.action = ACT_ADD_DAYS;
            cmd.amount = pick_amount(400, 4000);
        end else if (pick < 75) begin
            cmd.action = ACT_ADD_MONTHS;
            cmd.amount = pick_amount(30, 1500);
        end else if (pick < 95) begin
            cmd.action = ACT_ADD_YEARS;
            cmd.amount = pick_amount(12, 500);
        end else begin
            cmd.action = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        return cmd;
    endfunction

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("gregorian_date_adder_tb NOT OK");
        $finish;
    end

    initial begin
        int hold_at;
        int calm_from;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_fields(ACT_READ, 0, 0, 0, 0);
        // Latest storable date: every add must overflow.
        send_fields(ACT_SET, YEAR_LIMIT, 12, 31, 0);
        send_fields(ACT_ADD_DAYS, 0, 0, 0, 1);
        send_fields(ACT_ADD_MONTHS, 0, 0, 0, 1);
        send_fields(ACT_ADD_YEARS, 0, 0, 0, 1);
        // Set checks: year first, then month, then day.
        send_fields(ACT_SET, YEAR_MAX, 15, 31, 0);
        send_fields(ACT_SET, YEAR_LIMIT + 1, 1, 1, 0);
        send_fields(ACT_SET, 2000, 0, 1, 0);
        send_fields(ACT_SET, 2000, 13, 1, 0);
        send_fields(ACT_SET, 1900, 2, 29, 0);
        send_fields(ACT_SET, 2001, 4, 31, 0);
        send_fields(ACT_SET, 2001, 4, 0, 0);
        // Year zero is a leap year; February 29 moved by years.
        send_fields(ACT_SET, 0, 2, 29, 0);
        send_fields(ACT_ADD_YEARS, 0, 0, 0, 1);
        send_fields(ACT_ADD_YEARS, 0, 0, 0, 100);
        send_fields(ACT_ADD_YEARS, 0, 0, 0, 400);
        send_fields(ACT_ADD_DAYS, 0, 0, 0, 0);
        send_fields(ACT_SET, 2000, 1, 31, 0);
        send_fields(ACT_ADD_MONTHS, 0, 0, 0, 1);
        send_fields(ACT_ADD_MONTHS, 0, 0, 0, 0);
        send_fields(ACT_SET, 0, 1, 1, 0);
        send_fields(ACT_ADD_DAYS, 0, 0, 0, 16'hFFFF);
        send_fields(ACT_ADD_YEARS, 0, 0, 0, 16'hFFFF);
        send_fields(ACT_SPARE_LO, YEAR_MAX, 15, 31, 16'hFFFF);
        send_fields(ACT_SPARE_HI, YEAR_MAX, 15, 31, 16'hFFFF);
        n_directed = sent;

        hold_at   = $urandom_range(200, 600);
        calm_from = $urandom_range(700, 1300);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= calm_from) && (n < calm_from + CALM_ITEMS);
            if (n == hold_at) hold_request = 1'b1;
            send_command(random_command());
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        while (results_checked != sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands (%0d directed corners, rest random) and %0d results,",
                 sent, n_directed, results_checked);
        $display("%0d of them rejected with an error status, with one long output hold.",
                 rejected);
        if (mismatches == 0) begin
            $display("gregorian_date_adder_tb OK");
        end else begin
            $display("gregorian_date_adder_tb NOT OK");
        end
        $finish;
    end

endmodule
